@@ hw/rtl/rrd_pkg.sv @@
package rrd_pkg;

  // Position range: the effective line width saturates to the largest position count
  localparam int          POS_BITS    = 16;
  localparam logic [15:0] POS_MAX     = 16'((32'd1 << POS_BITS) - 32'd1);

  // Line width register reset value
  localparam logic [15:0] WIDTH_RESET = 16'd1024;

  // Byte codes of the scanline format
  localparam logic [7:0]  NEW_TAG     = 8'd2;    // new-style header: 2,2,len_hi,len_lo
  localparam logic [7:0]  RUN_TAG     = 8'd1;    // old-style run word: 1,1,1,n
  localparam logic [7:0]  RUN_LIMIT   = 8'd128;  // count byte above this is a run
  localparam logic [7:0]  RUN_MASK    = 8'd127;

  // Old-style run shift: grows by one byte per consecutive run word, saturates
  localparam logic [4:0]  SHIFT_STEP  = 5'd8;
  localparam logic [4:0]  SHIFT_SAT   = 5'd16;
  localparam logic [4:0]  SHIFT_MAX   = 5'd24;

  // Plane codes
  localparam logic [1:0]  PLANE_LAST  = 2'd3;    // exponent plane
  localparam logic [2:0]  PLANE_PIXEL = 3'd4;    // whole pixel

  localparam logic [1:0]  SLOT_LAST   = 2'd3;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_OLD     = 3'd1,
    PH_COUNT   = 3'd2,
    PH_RUNVAL  = 3'd3,
    PH_LITERAL = 3'd4
  } phase_t;

  typedef struct packed {
    logic [2:0]  plane;
    logic [15:0] position;
    logic [15:0] count;
    logic [31:0] value;
    logic        line_done;
  } cmd_t;

endpackage

@@ hw/rtl/rrd_if.sv @@
// Encoded byte stream
interface rrd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// Write command stream
interface rrd_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  plane;
  logic [15:0] position;
  logic [15:0] count;
  logic [31:0] value;
  logic        line_done;
  modport source (output valid, output plane, output position, output count,
                  output value, output line_done, input ready);
  modport sink   (input valid, input plane, input position, input count,
                  input value, input line_done, output ready);
endinterface

// Line width register write
interface rrd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/rgbe_rle_scanline_decoder.sv @@
// Channel  Dir  Payload                                   Handshake
// cfg      in   data[15:0] line width                     valid/ready, ready tied high
// src      in   data_byte[7:0]                            valid/ready
// cmd      out  plane, position, count, value, line_done  valid/ready
//
// One byte is taken per cycle while src.ready is high; its command, if any, is registered in
// cmd_q, or in the one-entry skid register while cmd is stalled. The decode state updates in
// the cycle the byte is taken; the skid register lets src keep flowing while cmd is stalled.
// src.ready drops only while the skid register holds a command.
// rst is synchronous: line width returns to 1024, the decoder waits for a line header.
module rgbe_rle_scanline_decoder (
  input  logic      clk,
  input  logic      rst,
  rrd_cfg_if.sink   cfg,
  rrd_byte_if.sink  src,
  rrd_cmd_if.source cmd
);
  import rrd_pkg::*;

  // Decode state
  logic [15:0] line_width;
  phase_t      phase, phase_next;
  logic [1:0]  byte_slot, byte_slot_next;
  logic [23:0] held_bytes, held_bytes_next;
  logic [1:0]  plane_index, plane_index_next;
  logic [15:0] pixel_position, pixel_position_next;
  logic [15:0] line_length, line_length_next;
  logic [7:0]  pending_count, pending_count_next;
  logic [4:0]  run_shift, run_shift_next;
  logic [31:0] last_pixel, last_pixel_next;
  logic        restart;

  // Output side
  cmd_t        cmd_q, skid_q, res;
  logic        cmd_valid, skid_valid, res_valid;

  logic        acc;
  logic [7:0]  d, r, g, b;
  logic [15:0] eff_width, new_len, new_len_clip;
  logic        is_header, is_new_tag, is_run_word, word_end;
  logic [15:0] word_len, word_pos, word_left, run_cnt;
  logic [4:0]  word_shift, shift_up;
  logic [31:0] run_n, word_pixel;
  logic [16:0] run_end, one_end;
  logic [15:0] plane_left, rv_cnt;
  logic [16:0] rv_end, lt_end;
  logic        rv_full, lt_full, last_plane;
  logic [7:0]  pending_dec;

  assign acc       = src.valid && src.ready;
  assign src.ready = !skid_valid;
  assign cfg.ready = 1'b1;

  // Byte fields of a completed word
  assign d = src.data_byte;
  assign r = held_bytes[7:0];
  assign g = held_bytes[15:8];
  assign b = held_bytes[23:16];

  assign word_end    = (byte_slot == SLOT_LAST);
  assign is_header   = (phase == PH_HEADER);
  assign is_new_tag  = (r == NEW_TAG) && (g == NEW_TAG);
  assign is_run_word = (r == RUN_TAG) && (g == RUN_TAG) && (b == RUN_TAG);

  // Line length choices at a header
  assign eff_width    = (line_width > POS_MAX) ? POS_MAX : line_width;
  assign new_len      = {b, d};
  assign new_len_clip = (new_len > eff_width) ? eff_width : new_len;

  // Old-style word arithmetic; at a header the line starts fresh
  assign word_len   = is_header ? eff_width : line_length;
  assign word_pos   = is_header ? 16'd0 : pixel_position;
  assign word_shift = is_header ? 5'd0 : run_shift;
  assign word_left  = word_len - word_pos;
  assign run_n      = 32'(d) << word_shift;
  assign run_cnt    = (run_n > 32'(word_left)) ? word_left : run_n[15:0];
  assign run_end    = {1'b0, word_pos} + {1'b0, run_cnt};
  assign one_end    = {1'b0, word_pos} + 17'd1;
  assign shift_up   = (word_shift >= SHIFT_SAT) ? SHIFT_MAX : word_shift + SHIFT_STEP;
  assign word_pixel = {d, b, g, r};

  // New-style plane arithmetic
  assign plane_left  = line_length - pixel_position;
  assign rv_cnt      = (16'(pending_count) > plane_left) ? plane_left : 16'(pending_count);
  assign rv_end      = {1'b0, pixel_position} + {1'b0, rv_cnt};
  assign lt_end      = {1'b0, pixel_position} + 17'd1;
  assign rv_full     = (rv_end >= {1'b0, line_length});
  assign lt_full     = (lt_end >= {1'b0, line_length});
  assign last_plane  = (plane_index >= PLANE_LAST);
  assign pending_dec = (pending_count == 8'd0) ? 8'd0 : pending_count - 8'd1;

  // Next state
  always_comb begin
    phase_next          = phase;
    byte_slot_next      = byte_slot;
    held_bytes_next     = held_bytes;
    plane_index_next    = plane_index;
    pixel_position_next = pixel_position;
    line_length_next    = line_length;
    pending_count_next  = pending_count;
    run_shift_next      = run_shift;
    last_pixel_next     = last_pixel;
    restart             = 1'b0;
    if (acc) begin
      unique case (phase)
        PH_HEADER, PH_OLD: begin
          if (!word_end) begin
            held_bytes_next = held_bytes | (24'(d) << {byte_slot, 3'b000});
            byte_slot_next  = byte_slot + 2'd1;
          end else begin
            held_bytes_next = '0;
            byte_slot_next  = '0;
            if (is_header && is_new_tag) begin
              line_length_next = new_len_clip;
              if (new_len_clip == 16'd0) begin
                restart = 1'b1;
              end else begin
                plane_index_next    = '0;
                pixel_position_next = '0;
                phase_next          = PH_COUNT;
              end
            end else if (is_header && (eff_width == 16'd0)) begin
              line_length_next = '0;
              restart          = 1'b1;
            end else begin
              line_length_next = word_len;
              if (is_run_word) begin
                run_shift_next = shift_up;
                if (run_cnt == 16'd0) begin
                  pixel_position_next = word_pos;
                  phase_next          = PH_OLD;
                end else if (run_end >= {1'b0, word_len}) begin
                  restart = 1'b1;
                end else begin
                  pixel_position_next = run_end[15:0];
                  phase_next          = PH_OLD;
                end
              end else begin
                last_pixel_next = word_pixel;
                run_shift_next  = '0;
                if (one_end >= {1'b0, word_len}) begin
                  restart = 1'b1;
                end else begin
                  pixel_position_next = one_end[15:0];
                  phase_next          = PH_OLD;
                end
              end
            end
          end
        end
        PH_COUNT: begin
          if (d > RUN_LIMIT) begin
            pending_count_next = d & RUN_MASK;
            phase_next         = PH_RUNVAL;
          end else if (d != 8'd0) begin
            pending_count_next = d;
            phase_next         = PH_LITERAL;
          end
        end
        PH_RUNVAL: begin
          pending_count_next = '0;
          phase_next         = PH_COUNT;
          if (!rv_full) begin
            pixel_position_next = rv_end[15:0];
          end else if (last_plane) begin
            restart = 1'b1;
          end else begin
            plane_index_next    = plane_index + 2'd1;
            pixel_position_next = '0;
          end
        end
        PH_LITERAL: begin
          pending_count_next = pending_dec;
          phase_next         = (pending_dec == 8'd0) ? PH_COUNT : PH_LITERAL;
          if (!lt_full) begin
            pixel_position_next = lt_end[15:0];
          end else if (last_plane) begin
            restart = 1'b1;
          end else begin
            plane_index_next    = plane_index + 2'd1;
            pixel_position_next = '0;
            pending_count_next  = '0;
            phase_next          = PH_COUNT;
          end
        end
        default: begin
          restart = 1'b1;
        end
      endcase
      // Line start clears the per-line state
      if (restart) begin
        phase_next          = PH_HEADER;
        byte_slot_next      = '0;
        held_bytes_next     = '0;
        plane_index_next    = '0;
        pixel_position_next = '0;
        pending_count_next  = '0;
        run_shift_next      = '0;
      end
    end
  end

  // Command produced by the accepted byte
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    if (acc) begin
      unique case (phase)
        PH_HEADER, PH_OLD: begin
          if (word_end) begin
            if (is_header && is_new_tag) begin
              if (new_len_clip == 16'd0) begin
                res_valid     = 1'b1;
                res.plane     = PLANE_PIXEL;
                res.line_done = 1'b1;
              end
            end else if (is_header && (eff_width == 16'd0)) begin
              res_valid     = 1'b1;
              res.plane     = PLANE_PIXEL;
              res.line_done = 1'b1;
            end else if (is_run_word) begin
              res_valid     = (run_cnt != 16'd0);
              res.plane     = PLANE_PIXEL;
              res.position  = word_pos;
              res.count     = run_cnt;
              res.value     = last_pixel;
              res.line_done = (run_end >= {1'b0, word_len});
            end else begin
              res_valid     = 1'b1;
              res.plane     = PLANE_PIXEL;
              res.position  = word_pos;
              res.count     = 16'd1;
              res.value     = word_pixel;
              res.line_done = (one_end >= {1'b0, word_len});
            end
          end
        end
        PH_RUNVAL: begin
          res_valid     = 1'b1;
          res.plane     = {1'b0, plane_index};
          res.position  = pixel_position;
          res.count     = rv_cnt;
          res.value     = 32'(d);
          res.line_done = rv_full && last_plane;
        end
        PH_LITERAL: begin
          res_valid     = 1'b1;
          res.plane     = {1'b0, plane_index};
          res.position  = pixel_position;
          res.count     = 16'd1;
          res.value     = 32'(d);
          res.line_done = lt_full && last_plane;
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width     <= WIDTH_RESET;
      phase          <= PH_HEADER;
      byte_slot      <= '0;
      held_bytes     <= '0;
      plane_index    <= '0;
      pixel_position <= '0;
      line_length    <= '0;
      pending_count  <= '0;
      run_shift      <= '0;
      last_pixel     <= '0;
    end else begin
      if (cfg.valid) begin
        line_width <= cfg.data;
      end
      phase          <= phase_next;
      byte_slot      <= byte_slot_next;
      held_bytes     <= held_bytes_next;
      plane_index    <= plane_index_next;
      pixel_position <= pixel_position_next;
      line_length    <= line_length_next;
      pending_count  <= pending_count_next;
      run_shift      <= run_shift_next;
      last_pixel     <= last_pixel_next;
    end
  end

  // Command register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!cmd_valid || cmd.ready) begin
      if (skid_valid) begin
        cmd_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        cmd_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd_valid || cmd.ready) begin
      cmd_q <= skid_valid ? skid_q : res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign cmd.valid     = cmd_valid;
  assign cmd.plane     = cmd_q.plane;
  assign cmd.position  = cmd_q.position;
  assign cmd.count     = cmd_q.count;
  assign cmd.value     = cmd_q.value;
  assign cmd.line_done = cmd_q.line_done;

endmodule
